// ----- rtl/core/square_channel_envelope_length_assert.svh -----
// assertion macros for the square channel block
`ifndef SQUARE_CHANNEL_ENVELOPE_LENGTH_ASSERT_SVH
`define SQUARE_CHANNEL_ENVELOPE_LENGTH_ASSERT_SVH

// antecedent holds, consequent holds in the same cycle
`define SCEL_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scel assertion failed");

// antecedent holds, consequent holds in the next cycle
`define SCEL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scel assertion failed");

`endif

// ----- rtl/core/scel_pkg.sv -----
// shared types and constants for the square channel block
package scel_pkg;

  // operation codes
  localparam logic [2:0] FUNC_WRITE    = 3'd0;
  localparam logic [2:0] FUNC_READ     = 3'd1;
  localparam logic [2:0] FUNC_PERIOD   = 3'd2;
  localparam logic [2:0] FUNC_ENVELOPE = 3'd3;
  localparam logic [2:0] FUNC_LENGTH   = 3'd4;

  // register addresses
  localparam logic [15:0] ADDR_LENGTH_DUTY = 16'hFF16;
  localparam logic [15:0] ADDR_ENVELOPE    = 16'hFF17;
  localparam logic [15:0] ADDR_PERIOD_LOW  = 16'hFF18;
  localparam logic [15:0] ADDR_CONTROL     = 16'hFF19;

  // read masks and fixed values
  localparam logic [7:0] RD_MASK_DUTY    = 8'hC0;
  localparam logic [6:0] RD_MASK_CONTROL = 7'h40;
  localparam logic [7:0] RD_PERIOD_LOW   = 8'hFF;

  // counter limits
  localparam logic [10:0] PERIOD_LAST = 11'h7FF;
  localparam logic [3:0]  VOL_MAX     = 4'd15;
  localparam logic [3:0]  VOL_RESET   = 4'd15;

  typedef struct packed {
    logic [2:0]  func;
    logic [15:0] address;
    logic [7:0]  write_data;
  } item_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        illegal_access;
    logic        channel_on;
    logic [3:0]  volume;
    logic [10:0] period_count;
  } result_t;

endpackage

// ----- rtl/core/scel_chan.sv -----
// channel registers, envelope, length timer and period divider update
module scel_chan (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_en,
  input  scel_pkg::item_t   item,
  output scel_pkg::result_t result
);

  logic [7:0]  ld_r, ld_nxt;
  logic [7:0]  env_r, env_nxt;
  logic [7:0]  plo_r, plo_nxt;
  logic [6:0]  ctl_r, ctl_nxt;
  logic        en_r, en_nxt;
  logic [5:0]  len_r, len_nxt;
  logic [10:0] pcnt_r, pcnt_nxt;
  logic [2:0]  ecnt_r, ecnt_nxt;
  logic [3:0]  vol_r, vol_nxt;

  logic        is_ld, is_env, is_plo, is_ctl;
  logic [2:0]  pace;
  logic [2:0]  ecnt_inc;
  logic [5:0]  len_dec;
  logic [7:0]  rd;
  logic        bad;

  // address decode and helper values
  assign is_ld    = (item.address == scel_pkg::ADDR_LENGTH_DUTY);
  assign is_env   = (item.address == scel_pkg::ADDR_ENVELOPE);
  assign is_plo   = (item.address == scel_pkg::ADDR_PERIOD_LOW);
  assign is_ctl   = (item.address == scel_pkg::ADDR_CONTROL);
  assign pace     = env_r[2:0];
  assign ecnt_inc = ecnt_r + 3'd1;
  assign len_dec  = (len_r != 6'd0) ? len_r - 6'd1 : 6'd0;

  // next state for one item
  always_comb begin
    ld_nxt   = ld_r;
    env_nxt  = env_r;
    plo_nxt  = plo_r;
    ctl_nxt  = ctl_r;
    en_nxt   = en_r;
    len_nxt  = len_r;
    pcnt_nxt = pcnt_r;
    ecnt_nxt = ecnt_r;
    vol_nxt  = vol_r;
    rd       = 8'd0;
    bad      = 1'b0;
    case (item.func)
      scel_pkg::FUNC_WRITE: begin
        if (is_ld) begin
          ld_nxt = item.write_data;
        end else if (is_env) begin
          env_nxt = item.write_data;
        end else if (is_plo) begin
          plo_nxt = item.write_data;
        end else if (is_ctl) begin
          ctl_nxt = item.write_data[6:0];
          // trigger: turn on, restart envelope, reload an empty length timer
          if (item.write_data[7]) begin
            en_nxt   = 1'b1;
            ecnt_nxt = 3'd0;
            vol_nxt  = env_r[7:4];
            if (len_r == 6'd0) begin
              len_nxt = ~ld_r[5:0];
            end
          end
        end else begin
          bad = 1'b1;
        end
      end
      scel_pkg::FUNC_READ: begin
        if (is_ld) begin
          rd = ld_r & scel_pkg::RD_MASK_DUTY;
        end else if (is_env) begin
          rd = env_r;
        end else if (is_plo) begin
          rd = scel_pkg::RD_PERIOD_LOW;
        end else if (is_ctl) begin
          rd = {1'b0, ctl_r & scel_pkg::RD_MASK_CONTROL};
        end else begin
          bad = 1'b1;
        end
      end
      scel_pkg::FUNC_PERIOD: begin
        // reload from the 11-bit period on overflow
        if (pcnt_r == scel_pkg::PERIOD_LAST) begin
          pcnt_nxt = {ctl_r[2:0], plo_r};
        end else begin
          pcnt_nxt = pcnt_r + 11'd1;
        end
      end
      scel_pkg::FUNC_ENVELOPE: begin
        // step volume once per pace events, saturating
        if (pace != 3'd0) begin
          if (ecnt_inc >= pace) begin
            ecnt_nxt = 3'd0;
            if (!env_r[3]) begin
              if (vol_r != 4'd0) vol_nxt = vol_r - 4'd1;
            end else begin
              if (vol_r != scel_pkg::VOL_MAX) vol_nxt = vol_r + 4'd1;
            end
          end else begin
            ecnt_nxt = ecnt_inc;
          end
        end
      end
      scel_pkg::FUNC_LENGTH: begin
        // count down, switch off on expiry when length enable is set
        if (en_r) begin
          len_nxt = len_dec;
          if (ctl_r[6] && (len_dec == 6'd0)) begin
            en_nxt = 1'b0;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // result reports state after the item
  always_comb begin
    result.read_data      = rd;
    result.illegal_access = bad;
    result.channel_on     = en_nxt;
    result.volume         = vol_nxt;
    result.period_count   = pcnt_nxt;
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ld_r   <= 8'd0;
      env_r  <= 8'd0;
      plo_r  <= 8'd0;
      ctl_r  <= 7'd0;
      en_r   <= 1'b0;
      len_r  <= 6'd0;
      pcnt_r <= 11'd0;
      ecnt_r <= 3'd0;
      vol_r  <= scel_pkg::VOL_RESET;
    end else if (step_en) begin
      ld_r   <= ld_nxt;
      env_r  <= env_nxt;
      plo_r  <= plo_nxt;
      ctl_r  <= ctl_nxt;
      en_r   <= en_nxt;
      len_r  <= len_nxt;
      pcnt_r <= pcnt_nxt;
      ecnt_r <= ecnt_nxt;
      vol_r  <= vol_nxt;
    end
  end

endmodule

// ----- rtl/core/square_channel_envelope_length.sv -----
// Square-wave sound channel with volume envelope, length timer and period
// divider, driven by one operation per item (register write or read, period
// tick, envelope event, length event). Each item gives exactly one result.
// Throughput is one item per clock while the output is not stalled: an item
// is captured in an input register and passes through a single stage of
// update logic into the result register. The state update of one item feeds
// the next item directly, with no extra wait. The input register stalls only
// while it holds an item and the result register is full and stalled.
module square_channel_envelope_length (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_func,
  input  logic [15:0] in_address,
  input  logic [7:0]  in_write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_read_data,
  output logic        out_illegal_access,
  output logic        out_channel_on,
  output logic [3:0]  out_volume,
  output logic [10:0] out_period_count
);

  logic              s1_valid_r;
  scel_pkg::item_t   s1_item_r;
  logic              out_valid_r;
  scel_pkg::result_t out_res_r;
  scel_pkg::result_t res;
  logic              advance;
  logic              in_take;

  // handshake control
  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r.func       <= in_func;
      s1_item_r.address    <= in_address;
      s1_item_r.write_data <= in_write_data;
    end
  end

  // channel state and update logic
  scel_chan u_chan (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (advance),
    .item    (s1_item_r),
    .result  (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_read_data      = out_res_r.read_data;
  assign out_illegal_access = out_res_r.illegal_access;
  assign out_channel_on     = out_res_r.channel_on;
  assign out_volume         = out_res_r.volume;
  assign out_period_count   = out_res_r.period_count;

  // checks
  `include "square_channel_envelope_length_assert.svh"

  `SCEL_ASSERT_SAME(a_illegal_reads_zero, out_valid && out_illegal_access, out_read_data == 8'd0)
  `SCEL_ASSERT_NEXT(a_held_item_kept, s1_valid_r && !advance, s1_valid_r)
  `SCEL_ASSERT_SAME(a_stall_needs_item, in_stall, s1_valid_r && out_valid_r)

endmodule

// ----- tb/square_channel_envelope_length_test.sv -----
// self-checking testbench for the square channel block with envelope and length timer
module square_channel_envelope_length_test;
  timeunit 1ns;
  timeprecision 1ps;

  // operation codes the block treats as no operation
  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

  // register field positions
  localparam int TRIGGER_BIT    = 7;
  localparam int LEN_ENABLE_BIT = 6;
  localparam int ENV_UP_BIT     = 3;

  // addresses just outside the register window
  localparam logic [15:0] ADDR_BELOW = 16'hFF15;
  localparam logic [15:0] ADDR_ABOVE = 16'hFF1A;

  localparam int RESET_CYCLES = 12;
  localparam int PHASE_ITEMS  = 250;
  localparam int TAIL_CYCLES  = 20;
  localparam int CYCLE_LIMIT  = 200000;

  // channel state tracker and queue of expected status items
  class channel_tracker;
    logic [7:0]        length_duty;
    logic [7:0]        envelope;
    logic [7:0]        period_low;
    logic [6:0]        control;
    logic              enabled;
    logic [5:0]        length_left;
    logic [10:0]       period_counter;
    logic [2:0]        env_count;
    logic [3:0]        volume;
    scel_pkg::result_t expected_status[$];
    int                errors;

    function new();
      length_duty    = '0;
      envelope       = '0;
      period_low     = '0;
      control        = '0;
      enabled        = 1'b0;
      length_left    = '0;
      period_counter = '0;
      env_count      = '0;
      volume         = scel_pkg::VOL_RESET;
      errors         = 0;
    endfunction

    function int pending();
      return expected_status.size();
    endfunction

    // apply one accepted item to the state and queue the status it gives
    function void note_item(scel_pkg::item_t it);
      scel_pkg::result_t r;
      logic [2:0] pace;
      r = '0;
      case (it.func)
        scel_pkg::FUNC_WRITE: begin
          case (it.address)
            scel_pkg::ADDR_LENGTH_DUTY: length_duty = it.write_data;
            scel_pkg::ADDR_ENVELOPE:    envelope = it.write_data;
            scel_pkg::ADDR_PERIOD_LOW:  period_low = it.write_data;
            scel_pkg::ADDR_CONTROL: begin
              control = it.write_data[6:0];
              // trigger: turn on, restart envelope, reload an empty length timer
              if (it.write_data[TRIGGER_BIT]) begin
                enabled   = 1'b1;
                env_count = '0;
                volume    = envelope[7:4];
                if (length_left == 0)
                  length_left = 6'd63 - length_duty[5:0];
              end
            end
            default: r.illegal_access = 1'b1;
          endcase
        end
        scel_pkg::FUNC_READ: begin
          case (it.address)
            scel_pkg::ADDR_LENGTH_DUTY:
              r.read_data = length_duty & scel_pkg::RD_MASK_DUTY;
            scel_pkg::ADDR_ENVELOPE:    r.read_data = envelope;
            scel_pkg::ADDR_PERIOD_LOW:  r.read_data = scel_pkg::RD_PERIOD_LOW;
            scel_pkg::ADDR_CONTROL:
              r.read_data = {1'b0, control & scel_pkg::RD_MASK_CONTROL};
            default:                    r.illegal_access = 1'b1;
          endcase
        end
        scel_pkg::FUNC_PERIOD: begin
          if (period_counter == scel_pkg::PERIOD_LAST)
            period_counter = {control[2:0], period_low};
          else
            period_counter = period_counter + 11'd1;
        end
        scel_pkg::FUNC_ENVELOPE: begin
          pace = envelope[2:0];
          if (pace != 0) begin
            env_count = env_count + 3'd1;
            if (env_count >= pace) begin
              env_count = '0;
              if (!envelope[ENV_UP_BIT]) begin
                if (volume != 0)
                  volume = volume - 4'd1;
              end else if (volume != scel_pkg::VOL_MAX) begin
                volume = volume + 4'd1;
              end
            end
          end
        end
        scel_pkg::FUNC_LENGTH: begin
          if (enabled) begin
            if (length_left != 0)
              length_left = length_left - 6'd1;
            if (control[LEN_ENABLE_BIT] && length_left == 0)
              enabled = 1'b0;
          end
        end
        default: ;
      endcase
      r.channel_on   = enabled;
      r.volume       = volume;
      r.period_count = period_counter;
      expected_status.push_back(r);
    endfunction

    // compare one status item against the oldest expectation
    function void check_status(scel_pkg::result_t got);
      scel_pkg::result_t exp_r;
      if (expected_status.size() == 0) begin
        $error("status item with nothing expected: %h", got);
        errors++;
        return;
      end
      exp_r = expected_status.pop_front();
      if (got.read_data !== exp_r.read_data) begin
        $error("read_data: expected %h, got %h", exp_r.read_data, got.read_data);
        errors++;
      end
      if (got.illegal_access !== exp_r.illegal_access) begin
        $error("illegal_access: expected %b, got %b", exp_r.illegal_access,
               got.illegal_access);
        errors++;
      end
      if (got.channel_on !== exp_r.channel_on) begin
        $error("channel_on: expected %b, got %b", exp_r.channel_on, got.channel_on);
        errors++;
      end
      if (got.volume !== exp_r.volume) begin
        $error("volume: expected %h, got %h", exp_r.volume, got.volume);
        errors++;
      end
      if (got.period_count !== exp_r.period_count) begin
        $error("period_count: expected %h, got %h", exp_r.period_count,
               got.period_count);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_func = '0;
  logic [15:0] in_address = '0;
  logic [7:0]  in_write_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_read_data;
  logic        out_illegal_access;
  logic        out_channel_on;
  logic [3:0]  out_volume;
  logic [10:0] out_period_count;

  channel_tracker    tracker;
  scel_pkg::result_t seen_status;
  int                idle_pct = 0;
  int                stall_pct = 0;
  int                cycle_count = 0;

  square_channel_envelope_length u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_address         (in_address),
    .in_write_data      (in_write_data),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_read_data      (out_read_data),
    .out_illegal_access (out_illegal_access),
    .out_channel_on     (out_channel_on),
    .out_volume         (out_volume),
    .out_period_count   (out_period_count)
  );

  // 10 ns clock
  always #5 clk = ~clk;

  // receiver stalls at random
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // status monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_status.read_data      = out_read_data;
      seen_status.illegal_access = out_illegal_access;
      seen_status.channel_on     = out_channel_on;
      seen_status.volume         = out_volume;
      seen_status.period_count   = out_period_count;
      tracker.check_status(seen_status);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT)
      @(posedge clk);
    $display("DONE: errors detected");
    $finish;
  end

  // present one item, with random idle cycles ahead of it, and hold it until taken
  task automatic send_item(input logic [2:0] f, input logic [15:0] a,
                           input logic [7:0] d);
    scel_pkg::item_t it;
    it.func       = f;
    it.address    = a;
    it.write_data = d;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_func       <= f;
    in_address    <= a;
    in_write_data <= d;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    tracker.note_item(it);
  endtask

  // sender holds off until every expected status item has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.pending() != 0)
      @(posedge clk);
  endtask

  function automatic logic [15:0] reg_addr();
    case ($urandom_range(3))
      0:       return scel_pkg::ADDR_LENGTH_DUTY;
      1:       return scel_pkg::ADDR_ENVELOPE;
      2:       return scel_pkg::ADDR_PERIOD_LOW;
      default: return scel_pkg::ADDR_CONTROL;
    endcase
  endfunction

  // mostly legal register traffic and events, some noise
  task automatic send_random_item();
    int          pick;
    logic [15:0] a;
    logic [7:0]  d;
    pick = int'($urandom_range(99));
    a    = 16'($urandom_range(16'hFFFF));
    d    = 8'($urandom_range(8'hFF));
    if (pick < 30) begin
      a = reg_addr();
      // favour short length loads so the timer runs out
      if (a == scel_pkg::ADDR_LENGTH_DUTY && $urandom_range(1))
        d[5:0] = 6'($urandom_range(56, 63));
      send_item(scel_pkg::FUNC_WRITE, a, d);
    end else if (pick < 45) begin
      send_item(scel_pkg::FUNC_READ, reg_addr(), d);
    end else if (pick < 60) begin
      send_item(scel_pkg::FUNC_PERIOD, a, d);
    end else if (pick < 75) begin
      send_item(scel_pkg::FUNC_ENVELOPE, a, d);
    end else if (pick < 92) begin
      send_item(scel_pkg::FUNC_LENGTH, a, d);
    end else begin
      send_item(3'($urandom_range(FUNC_SPARE_HI)), a, d);
    end
  endtask

  initial begin
    tracker = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset values, extremes, saturation, triggers, bad addresses, spare codes
    send_item(scel_pkg::FUNC_READ, scel_pkg::ADDR_LENGTH_DUTY, 8'h00);
    send_item(scel_pkg::FUNC_READ, scel_pkg::ADDR_ENVELOPE, 8'h00);
    send_item(scel_pkg::FUNC_READ, scel_pkg::ADDR_PERIOD_LOW, 8'h00);
    send_item(scel_pkg::FUNC_READ, scel_pkg::ADDR_CONTROL, 8'h00);
    send_item(scel_pkg::FUNC_WRITE, scel_pkg::ADDR_LENGTH_DUTY, 8'hFF);
    send_item(scel_pkg::FUNC_WRITE, scel_pkg::ADDR_ENVELOPE, 8'hF9);
    send_item(scel_pkg::FUNC_WRITE, scel_pkg::ADDR_PERIOD_LOW, 8'hFF);
    send_item(scel_pkg::FUNC_WRITE, scel_pkg::ADDR_CONTROL, 8'hC7);
    send_item(scel_pkg::FUNC_ENVELOPE, 16'h0000, 8'h00);
    send_item(scel_pkg::FUNC_LENGTH, 16'hFFFF, 8'hFF);
    send_item(scel_pkg::FUNC_READ, scel_pkg::ADDR_CONTROL, 8'h00);
    send_item(scel_pkg::FUNC_READ, scel_pkg::ADDR_LENGTH_DUTY, 8'h00);
    send_item(scel_pkg::FUNC_WRITE, scel_pkg::ADDR_ENVELOPE, 8'h01);
    send_item(scel_pkg::FUNC_WRITE, scel_pkg::ADDR_CONTROL, 8'h80);
    send_item(scel_pkg::FUNC_ENVELOPE, 16'h0000, 8'h00);
    send_item(scel_pkg::FUNC_WRITE, scel_pkg::ADDR_LENGTH_DUTY, 8'h00);
    send_item(scel_pkg::FUNC_WRITE, scel_pkg::ADDR_CONTROL, 8'hFF);
    send_item(scel_pkg::FUNC_LENGTH, 16'h0000, 8'h00);
    send_item(scel_pkg::FUNC_PERIOD, 16'hFFFF, 8'hFF);
    send_item(scel_pkg::FUNC_WRITE, 16'h0000, 8'hFF);
    send_item(scel_pkg::FUNC_READ, 16'hFFFF, 8'h00);
    send_item(scel_pkg::FUNC_WRITE, ADDR_BELOW, 8'h55);
    send_item(scel_pkg::FUNC_READ, ADDR_ABOVE, 8'hAA);
    send_item(FUNC_SPARE_LO, 16'hFFFF, 8'hFF);
    send_item(FUNC_SPARE_HI, scel_pkg::ADDR_CONTROL, 8'hFF);
    wait_drained();

    // random phases: no idling, sender idle, receiver stalling, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 55; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 55; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++)
        send_random_item();
      wait_drained();
    end

    // let any stray status item show up
    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/scel_pkg.sv
rtl/core/scel_chan.sv
rtl/core/square_channel_envelope_length.sv
tb/square_channel_envelope_length_test.sv
